/* hw/rtl/chg_pkg.sv */
// Shared constants for the greedy change dispenser: denominations and field widths.
`timescale 1ns / 1ps
`default_nettype none

package chg_pkg;

	localparam int unsigned NUM_DENOMS      = 10;
	localparam int unsigned AMOUNT_BITS_DEF = 16;
	localparam int unsigned COUNT_BITS_DEF  = 8;

	localparam int unsigned USED_1000_W = 7;
	localparam int unsigned USED_W      = 8;

	// largest first
	localparam int unsigned DENOMS [NUM_DENOMS] = '{
		1000, 500, 200, 100, 50, 20, 10, 5, 2, 1
	};

endpackage

`default_nettype wire

/* hw/rtl/greedy_change_dispenser.sv */
// Top level of the greedy change dispenser: ten denomination stages in a chain.
//
//  channel | beat signals            | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid / in_ready     | amount, avail_1000 .. avail_1
//  out     | out_valid / out_ready   | used_1000 .. used_1, exact_ok
//
// One beat per cycle sustained while out is not stalled; two register levels per
// denomination (reciprocal multiply, then clamp to supply and subtract).
// Reset clears only the valid bits; payload registers are not reset.
// A stall on out propagates back stage by stage; empty stages keep filling,
// so no beat is dropped or duplicated.
`timescale 1ns / 1ps
`default_nettype none

module greedy_change_dispenser import chg_pkg::*; #(
	parameter int unsigned AMOUNT_BITS = AMOUNT_BITS_DEF,
	parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [AMOUNT_BITS-1:0]  amount,
	input  wire logic [COUNT_BITS-1:0]   avail_1000,
	input  wire logic [COUNT_BITS-1:0]   avail_500,
	input  wire logic [COUNT_BITS-1:0]   avail_200,
	input  wire logic [COUNT_BITS-1:0]   avail_100,
	input  wire logic [COUNT_BITS-1:0]   avail_50,
	input  wire logic [COUNT_BITS-1:0]   avail_20,
	input  wire logic [COUNT_BITS-1:0]   avail_10,
	input  wire logic [COUNT_BITS-1:0]   avail_5,
	input  wire logic [COUNT_BITS-1:0]   avail_2,
	input  wire logic [COUNT_BITS-1:0]   avail_1,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [USED_1000_W-1:0]       used_1000,
	output logic [USED_W-1:0]            used_500,
	output logic [USED_W-1:0]            used_200,
	output logic [USED_W-1:0]            used_100,
	output logic [USED_W-1:0]            used_50,
	output logic [USED_W-1:0]            used_20,
	output logic [USED_W-1:0]            used_10,
	output logic [USED_W-1:0]            used_5,
	output logic [USED_W-1:0]            used_2,
	output logic [USED_W-1:0]            used_1,
	output logic                         exact_ok
);

	logic                                   valid [NUM_DENOMS+1];
	logic                                   ready [NUM_DENOMS+1];
	logic [AMOUNT_BITS-1:0]                 left  [NUM_DENOMS+1];
	logic [NUM_DENOMS-1:0][COUNT_BITS-1:0]  avail [NUM_DENOMS+1];
	logic [NUM_DENOMS-1:0][COUNT_BITS-1:0]  used  [NUM_DENOMS+1];

	assign valid[0] = in_valid;
	assign in_ready = ready[0];
	assign left[0]  = amount;
	assign avail[0] = {avail_1, avail_2, avail_5, avail_10, avail_20,
	                   avail_50, avail_100, avail_200, avail_500, avail_1000};
	assign used[0]  = '0;

	for (genvar k = 0; k < NUM_DENOMS; k++) begin : g_denom
		// packed index 0 holds the largest denomination
		chg_stage #(
			.AMOUNT_BITS (AMOUNT_BITS),
			.COUNT_BITS  (COUNT_BITS),
			.IDX         (k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[k]),
			.in_ready  (ready[k]),
			.in_left   (left[k]),
			.in_avail  (avail[k]),
			.in_used   (used[k]),
			.out_valid (valid[k+1]),
			.out_ready (ready[k+1]),
			.out_left  (left[k+1]),
			.out_used  (used[k+1]),
			.out_avail (avail[k+1])
		);
	end

	assign out_valid         = valid[NUM_DENOMS];
	assign ready[NUM_DENOMS] = out_ready;

	// stage k reads packed slot k of a vector whose slot 0 sits at the low end,
	// i.e. slot k carries the denomination listed k-th from the top
	logic [NUM_DENOMS-1:0][COUNT_BITS-1:0] used_fin;

	assign used_fin = used[NUM_DENOMS];

	assign used_1000 = USED_1000_W'(used_fin[0]);
	assign used_500  = USED_W'(used_fin[1]);
	assign used_200  = USED_W'(used_fin[2]);
	assign used_100  = USED_W'(used_fin[3]);
	assign used_50   = USED_W'(used_fin[4]);
	assign used_20   = USED_W'(used_fin[5]);
	assign used_10   = USED_W'(used_fin[6]);
	assign used_5    = USED_W'(used_fin[7]);
	assign used_2    = USED_W'(used_fin[8]);
	assign used_1    = USED_W'(used_fin[9]);
	assign exact_ok  = (left[NUM_DENOMS] == '0);

`ifndef ASSERT_OFF
	// back-pressure only originates at the output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output stall");

	// a beat held between the first two stages is not lost or altered
	a_link_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid[1] && !ready[1]) |=> (valid[1] && $stable(left[1])))
		else $error("beat lost between denomination stages");

	// a stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(exact_ok) && $stable(used_1000) && $stable(used_1)))
		else $error("result beat changed while stalled");
`endif

endmodule

`default_nettype wire

/* hw/rtl/chg_stage.sv */
// One denomination of the dispenser: reciprocal divide, then clamp to supply and subtract.
`timescale 1ns / 1ps
`default_nettype none

module chg_stage import chg_pkg::*; #(
	parameter int unsigned AMOUNT_BITS = AMOUNT_BITS_DEF,
	parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF,
	parameter int unsigned IDX         = 0
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [AMOUNT_BITS-1:0]                 in_left,
	input  wire logic [NUM_DENOMS-1:0][COUNT_BITS-1:0]  in_avail,
	input  wire logic [NUM_DENOMS-1:0][COUNT_BITS-1:0]  in_used,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [AMOUNT_BITS-1:0]                      out_left,
	output logic [NUM_DENOMS-1:0][COUNT_BITS-1:0]       out_used,
	output logic [NUM_DENOMS-1:0][COUNT_BITS-1:0]       out_avail
);

	localparam longint unsigned DEN    = longint'(DENOMS[IDX]);
	localparam int unsigned     LOG_D  = $clog2(DEN);
	localparam int unsigned     SHIFT  = AMOUNT_BITS + LOG_D;
	localparam longint unsigned RECIP  = ((64'd1 << SHIFT) + DEN - 64'd1) / DEN;
	localparam int unsigned     PROD_W = 2 * AMOUNT_BITS + 1;
	localparam int unsigned     CMP_W  = (AMOUNT_BITS > COUNT_BITS) ? AMOUNT_BITS : COUNT_BITS;

	logic                                   valid_s1, valid_s2;
	logic                                   ready_s1, ready_s2;
	logic [AMOUNT_BITS-1:0]                 fit;
	logic [AMOUNT_BITS-1:0]                 left_s1, fit_s1, left_s2;
	logic [NUM_DENOMS-1:0][COUNT_BITS-1:0]  avail_s1, used_s1, avail_s2, used_s2;
	logic [COUNT_BITS-1:0]                  have, take;
	logic [AMOUNT_BITS-1:0]                 left_nxt;
	logic [NUM_DENOMS-1:0][COUNT_BITS-1:0]  used_nxt;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// floor(left / DEN) by multiply with rounded-up reciprocal
	if (DEN == 64'd1) begin : g_unit
		assign fit = in_left;
	end else begin : g_recip
		logic [PROD_W-1:0] prod;
		assign prod = PROD_W'(in_left) * PROD_W'(RECIP);
		assign fit  = AMOUNT_BITS'(prod >> SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			left_s1  <= in_left;
			fit_s1   <= fit;
			avail_s1 <= in_avail;
			used_s1  <= in_used;
		end
	end

	always_comb begin
		have = avail_s1[IDX];
		take = (CMP_W'(fit_s1) < CMP_W'(have)) ? COUNT_BITS'(fit_s1) : have;
		// take * DEN never exceeds left, so N-bit arithmetic is exact
		left_nxt = left_s1 - AMOUNT_BITS'(AMOUNT_BITS'(take) * AMOUNT_BITS'(DEN));
		used_nxt = used_s1;
		used_nxt[IDX] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			left_s2  <= left_nxt;
			avail_s2 <= avail_s1;
			used_s2  <= used_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_left  = left_s2;
	assign out_used  = used_s2;
	assign out_avail = avail_s2;

endmodule

`default_nettype wire
